### hw/rtl/cfd_pkg.sv
// Shared types and constants for the CPPM frame decoder.
package cfd_pkg;

  // Field widths
  localparam int unsigned TimeW    = 16;
  localparam int unsigned KindW    = 2;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned ValW     = 14;
  localparam int unsigned FracW    = 12;
  localparam int unsigned QuoW     = 13;
  localparam int unsigned DivCntW  = 4;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutUserW = 2;
  localparam int unsigned CfgIdxW  = 2;

  // Event kinds carried in the input tuser
  localparam logic [KindW-1:0] KindRise   = 2'd0;
  localparam logic [KindW-1:0] KindFall   = 2'd1;
  localparam logic [KindW-1:0] KindDecode = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMinPulse = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSpan     = 2'd1;

  // Register reset values and the substitute value for a bad channel
  localparam logic [TimeW-1:0] MinPulseRst = 16'd1000;
  localparam logic [TimeW-1:0] SpanRst     = 16'd1000;
  localparam logic [ValW-1:0]  HalfQ12     = 14'd2048;

  // Edge event toward the pulse ring
  typedef struct packed {
    logic             rise;
    logic             fall;
    logic [TimeW-1:0] time_us;
  } pulse_ev_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic            busy;
    logic [QuoW-1:0] quo;
    logic            rem_nz;
  } div_stat_t;

endpackage

### hw/rtl/cppm_frame_decoder.sv
// CPPM frame decoder top level: sequencer, range check and output register.
//
// Input stream: s_axis_tuser carries the event kind (rise, fall, decode),
// s_axis_tdata the 16-bit microsecond timestamp. Rise and fall items are
// taken while idle; a fall stores the pulse width in a ring of PULSES slots.
// A decode item scans the ring for the longest width, then produces CHANNELS
// result items from the widths after it. Each channel passes the range
// check, the divider state (13 quotient steps in the shared restoring
// divider) and the output register; an out-of-range channel skips the
// divider. After a decode item the next item is accepted only once the
// sequencer is back in idle; s_axis_tready is high only while idle.
// Config writes (cfg_valid_i, always ready) set min pulse and span; write
// them only while idle. Results sit in an output register; when the receiver
// stalls the sequencer holds the next channel until the register frees up.
// Reset clears the ring, the write slot and the rise time, and loads both
// registers with 1000.
module cppm_frame_decoder #(
  parameter int unsigned PULSES   = 9,
  parameter int unsigned CHANNELS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input: tdata = time_us[15:0]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cfd_pkg::TimeW-1:0]       s_axis_tdata,
  // input: tuser = kind[1:0]
  input  logic [cfd_pkg::KindW-1:0]       s_axis_tuser,
  // output: tdata = channel[2:0], value_q12[16:3], zero pad [23:17]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cfd_pkg::OutDataW-1:0]    m_axis_tdata,
  // output: tuser = channel_valid[0], frame_valid[1]
  output logic [cfd_pkg::OutUserW-1:0]    m_axis_tuser,
  output logic                            m_axis_tlast,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cfd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [cfd_pkg::TimeW-1:0]       cfg_data_i
);

  localparam int unsigned SlotW = $clog2(PULSES);
  localparam int unsigned CntW  = $clog2(CHANNELS + 1);
  localparam int unsigned TW    = cfd_pkg::TimeW;
  localparam int unsigned VW    = cfd_pkg::ValW;
  localparam int unsigned XW    = TW + 5;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StPrep = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [SlotW-1:0]   scan_q, ptr_q, sync_q;
  logic [SlotW-1:0]   rd_addr, sync_nx, ptr_inc;
  logic [TW-1:0]      longest_q, rd_data;
  logic [CntW-1:0]    ch_q;
  logic               all_ok_q, ok_q, neg_q;
  logic [TW-1:0]      min_q, span_q;
  logic               s_acc, m_free, last_ch;
  cfd_pkg::pulse_ev_t ev;
  cfd_pkg::div_stat_t dstat;
  logic               div_start;
  logic [TW:0]        mag;
  logic signed [TW:0] diff;
  logic signed [XW-1:0] dx, d10, spx, span11;
  logic               in_range;
  logic [VW-1:0]      qx, val;

  logic               out_valid_q;
  logic [cfd_pkg::ChanW-1:0] out_ch_q;
  logic [VW-1:0]      out_val_q;
  logic               out_cv_q, out_fv_q, out_last_q;

  assign s_axis_tready = (state_q == StIdle);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= cfd_pkg::MinPulseRst;
      span_q <= cfd_pkg::SpanRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == cfd_pkg::CfgMinPulse) begin
        min_q <= cfg_data_i;
      end else if (cfg_index_i == cfd_pkg::CfgSpan) begin
        span_q <= cfg_data_i;
      end
    end
  end

  // Edge events to the ring
  assign ev.rise    = s_acc && (s_axis_tuser == cfd_pkg::KindRise);
  assign ev.fall    = s_acc && (s_axis_tuser == cfd_pkg::KindFall);
  assign ev.time_us = s_axis_tdata;

  assign rd_addr = (state_q == StScan) ? scan_q : ptr_q;

  cfd_ring #(
    .PULSES(PULSES)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ev_i     (ev),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Range check on the current channel width
  assign diff   = $signed({1'b0, rd_data}) - $signed({1'b0, min_q});
  assign dx     = XW'(diff);
  assign d10    = (dx <<< 3) + (dx <<< 1);
  assign spx    = $signed(XW'({1'b0, span_q}));
  assign span11 = (spx <<< 3) + (spx <<< 1) + spx;
  assign in_range = (span_q != '0) && (d10 >= -spx) && (d10 <= span11);
  assign mag    = diff[TW] ? (TW + 1)'(-diff) : (TW + 1)'(diff);

  assign div_start = (state_q == StPrep) && in_range;

  cfd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .mag_i  (mag),
    .span_i (span_q),
    .stat_o (dstat)
  );

  // Floor for negative ratios: round the magnitude up before negating
  assign qx  = VW'(dstat.quo);
  assign val = !ok_q ? cfd_pkg::HalfQ12 :
               neg_q ? (VW'(0) - (qx + VW'(dstat.rem_nz))) : qx;

  assign sync_nx = (rd_data > longest_q) ? scan_q : sync_q;
  assign ptr_inc = (ptr_q == SlotW'(PULSES - 1)) ? '0 : ptr_q + SlotW'(1);
  assign last_ch = (ch_q == CntW'(CHANNELS - 1));
  assign m_free  = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (s_acc && (s_axis_tuser == cfd_pkg::KindDecode)) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (scan_q == SlotW'(PULSES - 1)) begin
          state_d = StPrep;
        end
      end
      StPrep: state_d = in_range ? StDiv : StEmit;
      StDiv: begin
        if (!dstat.busy) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (m_free) begin
          state_d = last_ch ? StIdle : StPrep;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      scan_q    <= '0;
      sync_q    <= '0;
      ptr_q     <= '0;
      longest_q <= '0;
      ch_q      <= '0;
      all_ok_q  <= 1'b1;
      ok_q      <= 1'b0;
      neg_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          scan_q    <= '0;
          sync_q    <= '0;
          longest_q <= '0;
        end
        StScan: begin
          sync_q <= sync_nx;
          if (rd_data > longest_q) begin
            longest_q <= rd_data;
          end
          scan_q <= scan_q + SlotW'(1);
          if (scan_q == SlotW'(PULSES - 1)) begin
            ptr_q    <= (sync_nx == SlotW'(PULSES - 1)) ? '0 : sync_nx + SlotW'(1);
            ch_q     <= '0;
            all_ok_q <= 1'b1;
          end
        end
        StPrep: begin
          ok_q  <= in_range;
          neg_q <= diff[TW];
        end
        StEmit: begin
          if (m_free) begin
            all_ok_q <= all_ok_q && ok_q;
            ch_q     <= ch_q + CntW'(1);
            ptr_q    <= ptr_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == StEmit) && m_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StEmit) && m_free) begin
      out_ch_q   <= cfd_pkg::ChanW'(ch_q);
      out_val_q  <= val;
      out_cv_q   <= ok_q;
      out_fv_q   <= last_ch && all_ok_q && ok_q;
      out_last_q <= last_ch;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(cfd_pkg::OutDataW - cfd_pkg::ChanW - VW){1'b0}},
                          out_val_q, out_ch_q};
  assign m_axis_tuser  = {out_fv_q, out_cv_q};
  assign m_axis_tlast  = out_last_q;

endmodule

### hw/rtl/cfd_ring.sv
// Pulse width ring with rise time capture and wrapping write slot.
module cfd_ring #(
  parameter int unsigned PULSES = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfd_pkg::pulse_ev_t            ev_i,
  input  logic [$clog2(PULSES)-1:0]     rd_addr_i,
  output logic [cfd_pkg::TimeW-1:0]     rd_data_o
);

  localparam int unsigned SlotW = $clog2(PULSES);

  logic [cfd_pkg::TimeW-1:0] ring_q [PULSES];
  logic [cfd_pkg::TimeW-1:0] rise_q;
  logic [SlotW-1:0]          slot_q, slot_d;
  logic [cfd_pkg::TimeW-1:0] width;

  // width modulo 2^16
  assign width = ev_i.time_us - rise_q;

  always_comb begin
    if (slot_q == SlotW'(PULSES - 1)) begin
      slot_d = '0;
    end else begin
      slot_d = slot_q + SlotW'(1);
    end
  end

  // Edge capture and ring write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q <= '0;
      slot_q <= '0;
      for (int i = 0; i < PULSES; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      if (ev_i.rise) begin
        rise_q <= ev_i.time_us;
      end
      if (ev_i.fall) begin
        ring_q[slot_q] <= width;
        slot_q         <= slot_d;
      end
    end
  end

  assign rd_data_o = ring_q[rd_addr_i];

endmodule

### hw/rtl/cfd_div.sv
// Restoring divider, one quotient bit per cycle: (mag << 12) / span.
module cfd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cfd_pkg::TimeW:0]     mag_i,
  input  logic [cfd_pkg::TimeW-1:0]   span_i,
  output cfd_pkg::div_stat_t          stat_o
);

  localparam int unsigned TW = cfd_pkg::TimeW;
  localparam int unsigned QW = cfd_pkg::QuoW;

  logic                        busy_q;
  logic [cfd_pkg::DivCntW-1:0] cnt_q;
  logic [TW-1:0]               rem_q;
  logic [QW-1:0]               dvd_q;
  logic [QW-1:0]               quo_q;
  logic [TW:0]                 trial;
  logic [TW:0]                 diffv;
  logic                        ge;

  // Shared compare and subtract step
  assign trial = {rem_q, dvd_q[QW-1]};
  assign ge    = trial >= {1'b0, span_i};
  assign diffv = trial - {1'b0, span_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= cfd_pkg::DivCntW'(QW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - cfd_pkg::DivCntW'(1);
      if (cnt_q == cfd_pkg::DivCntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: upper dividend bits seed the remainder, lower bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= mag_i[TW:1];
      dvd_q <= {mag_i[0], {cfd_pkg::FracW{1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diffv[TW-1:0] : trial[TW-1:0];
      dvd_q <= {dvd_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign stat_o.busy   = busy_q;
  assign stat_o.quo    = quo_q;
  assign stat_o.rem_nz = (rem_q != '0);

endmodule

### hw/rtl/cfd_checker.sv
// Port-level checks for the CPPM frame decoder, bound to the top level.
module cfd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [cfd_pkg::KindW-1:0]    s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [cfd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [cfd_pkg::OutUserW-1:0] m_axis_tuser,
  input logic                         m_axis_tlast
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A decode request blocks the input on the next cycle
  a_decode_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == cfd_pkg::KindDecode)
    |=> !s_axis_tready)
    else $error("input ready right after decode request");

  // Mid-frame results keep the input closed
  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready in the middle of a frame");

  // Frame valid only on the last channel
  a_fv_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser[1])
    else $error("frame valid before last channel");

  // An invalid channel reads one half
  a_bad_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[16:3] == cfd_pkg::HalfQ12)
    else $error("invalid channel value is not one half");

endmodule

bind cppm_frame_decoder cfd_checker u_cfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
